// ===== hdl/thin_film_field_amplitude_top_defines.svh =====
// Assertion macros for the thin-film field amplitude block
`ifndef THIN_FILM_FIELD_AMPLITUDE_TOP_DEFINES_SVH
`define THIN_FILM_FIELD_AMPLITUDE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TFFA_ASSERT(name, prop) name: assert property (@(posedge clock) disable iff (reset) \
   prop) else $error("thin film field amplitude check failed");
`define TFFA_ASSERT_NEXT(name, ante, cons) name: assert property (@(posedge clock) \
   disable iff (reset) (ante) |=> (cons)) else $error("thin film field amplitude check failed");
`else
`define TFFA_ASSERT(name, prop)
`define TFFA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hdl/tffa_pkg.sv =====
// Types, constants and arithmetic helpers for the thin-film field amplitude block
`default_nettype none
package tffa_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 24;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int SUM_W      = 2 * DATA_WIDTH + 4;
   localparam int ROOT_W     = DATA_WIDTH;
   localparam int RAD_W      = 2 * DATA_WIDTH;
   localparam int DIV_W      = 3 * DATA_WIDTH;
   localparam int QUO_W      = DATA_WIDTH;
   // 13 single stages, three root sections (the half-angle pair side by side) and the
   // paired quotient units, each a load stage followed by one stage per result bit
   localparam int PIPE_DEPTH = 13 + 3 * (ROOT_W + 1) + (QUO_W + 1);

   localparam logic [SUM_W-1:0] POS_LIM =
      {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [SUM_W-1:0] NEG_LIM = POS_LIM + SUM_W'(1);

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;

   typedef struct packed {
      logic     ovf;
      word_type val;
   } fit_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [RAD_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             big;
      logic             neg;
   } div_type;

   // side data that travels with each item
   typedef struct packed {
      logic     mode;
      logic     ovf;
      logic     zdiv;
      logic     z_neg;
      word_type m11_re;
      word_type m11_im;
      word_type m12_re;
      word_type m12_im;
      word_type n2_re;
      word_type n2_im;
      word_type z_re;
      word_type y_re;
      word_type y_im;
   } carry_type;

   function automatic sum_type ext_word(input word_type v);
      return {{(SUM_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
   endfunction

   function automatic sum_type ext_prod(input prod_type v);
      return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
   endfunction

   // optional truncation toward zero, then saturation to a word
   function automatic fit_type sat_fit(input sum_type v, input logic trunc);
      logic             neg;
      logic [SUM_W-1:0] mag;
      fit_type          f;
      neg = v[SUM_W-1];
      mag = neg ? $unsigned(-v) : $unsigned(v);
      if (trunc) begin
         mag = mag >> FRAC_BITS;
      end
      f.ovf = 1'b0;
      if (neg) begin
         if (mag > NEG_LIM) begin
            f.ovf = 1'b1;
            f.val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         end else begin
            f.val = -mag[DATA_WIDTH-1:0];
         end
      end else begin
         if (mag > POS_LIM) begin
            f.ovf = 1'b1;
            f.val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end else begin
            f.val = mag[DATA_WIDTH-1:0];
         end
      end
      return f;
   endfunction

   // one root bit: (root + 2^j)^2 <= n, tracked through rem = n - root^2
   function automatic sqrt_type sqrt_step(input sqrt_type s, input int j);
      logic [RAD_W+1:0] trial;
      sqrt_type         r;
      r     = s;
      trial = ({{(RAD_W+2-ROOT_W){1'b0}}, s.root} << (j + 1))
              + ((RAD_W+2)'(1) << (2 * j));
      if ({2'b00, s.rem} >= trial) begin
         r.rem  = s.rem - trial[RAD_W-1:0];
         r.root = s.root | (ROOT_W'(1) << j);
      end
      return r;
   endfunction

   // one restoring quotient bit
   function automatic div_type div_step(input div_type d, input int j);
      logic [DIV_W-1:0] shifted;
      div_type          r;
      r       = d;
      shifted = {{(DIV_W-RAD_W){1'b0}}, d.den} << j;
      if (d.rem >= shifted) begin
         r.rem = d.rem - shifted;
         r.quo = d.quo | (QUO_W'(1) << j);
      end
      return r;
   endfunction

   function automatic fit_type quo_fit(input div_type d);
      sum_type mag;
      sum_type v;
      mag = d.big ? {{(SUM_W-QUO_W-1){1'b0}}, {(QUO_W+1){1'b1}}}
                  : {{(SUM_W-QUO_W){1'b0}}, d.quo};
      v   = d.neg ? -mag : mag;
      return sat_fit(v, 1'b0);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/thin_film_field_amplitude_top.sv =====
// Thin-film field amplitude: substrate admittance and |m11 + m12*Y| per spectral point
//
// One spectral point is taken on every cycle that start is high; busy never rises, so
// points may follow back to back indefinitely. Each result appears on the rsp_ ports
// for exactly one cycle with rsp_valid high, and results leave in order; the receiver
// cannot hold results off. The pipeline is made of four bit-per-stage units: the
// modulus root, the paired half-angle roots, the final magnitude root and the p-mode
// quotients (33 stages each: a load stage and 32 bit stages), plus 13 single stages.
// The polarization register may only be written while no point is in flight.
`default_nettype none
`include "thin_film_field_amplitude_top_defines.svh"
module thin_film_field_amplitude_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [tffa_pkg::DATA_WIDTH-1:0]   req_index_re,
   input  logic signed [tffa_pkg::DATA_WIDTH-1:0]   req_index_im,
   input  logic signed [tffa_pkg::DATA_WIDTH-1:0]   req_sine_sq_re,
   input  logic signed [tffa_pkg::DATA_WIDTH-1:0]   req_sine_sq_im,
   input  logic signed [tffa_pkg::DATA_WIDTH-1:0]   req_m11_re,
   input  logic signed [tffa_pkg::DATA_WIDTH-1:0]   req_m11_im,
   input  logic signed [tffa_pkg::DATA_WIDTH-1:0]   req_m12_re,
   input  logic signed [tffa_pkg::DATA_WIDTH-1:0]   req_m12_im,
   output logic                                     rsp_valid,
   output logic        [tffa_pkg::DATA_WIDTH-2:0]   rsp_field_magnitude,
   output logic                                     rsp_overflow_flag,
   output logic                                     rsp_zero_divisor_flag,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic                                     csr_polarization_mode
);

   logic [tffa_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic                            mode_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign rsp_valid = valid_ff[tffa_pkg::PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mode_ff  <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[tffa_pkg::PIPE_DEPTH-2:0], start && !busy};
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_polarization_mode;
         end
      end
   end

   // stage 1: index products
   tffa_pkg::carry_type c1_in, c1_ff;
   tffa_pkg::prod_type  p_rr_ff, p_ii_ff, p_ri_ff;
   tffa_pkg::word_type  s2r1_ff, s2i1_ff;

   always_comb begin
      c1_in        = '0;
      c1_in.mode   = mode_ff;
      c1_in.m11_re = req_m11_re;
      c1_in.m11_im = req_m11_im;
      c1_in.m12_re = req_m12_re;
      c1_in.m12_im = req_m12_im;
   end

   always_ff @(posedge clock) begin
      p_rr_ff <= req_index_re * req_index_re;
      p_ii_ff <= req_index_im * req_index_im;
      p_ri_ff <= req_index_re * req_index_im;
      s2r1_ff <= req_sine_sq_re;
      s2i1_ff <= req_sine_sq_im;
      c1_ff   <= c1_in;
   end

   // stage 2: N^2
   tffa_pkg::carry_type c2_in, c2_ff;
   tffa_pkg::fit_type   n2r_fit, n2i_fit;
   tffa_pkg::word_type  s2r2_ff, s2i2_ff;

   always_comb begin
      n2r_fit = tffa_pkg::sat_fit(tffa_pkg::ext_prod(p_rr_ff) - tffa_pkg::ext_prod(p_ii_ff),
                                  1'b1);
      n2i_fit = tffa_pkg::sat_fit(tffa_pkg::ext_prod(p_ri_ff) <<< 1, 1'b1);
      c2_in       = c1_ff;
      c2_in.n2_re = n2r_fit.val;
      c2_in.n2_im = n2i_fit.val;
      c2_in.ovf   = c1_ff.ovf | n2r_fit.ovf | n2i_fit.ovf;
   end

   always_ff @(posedge clock) begin
      c2_ff   <= c2_in;
      s2r2_ff <= s2r1_ff;
      s2i2_ff <= s2i1_ff;
   end

   // stage 3: Z = N^2 - S
   tffa_pkg::carry_type c3_in, c3_ff;
   tffa_pkg::fit_type   zr_fit, zi_fit;
   tffa_pkg::word_type  zi3_ff;

   always_comb begin
      zr_fit = tffa_pkg::sat_fit(tffa_pkg::ext_word(c2_ff.n2_re) - tffa_pkg::ext_word(s2r2_ff),
                                 1'b0);
      zi_fit = tffa_pkg::sat_fit(tffa_pkg::ext_word(c2_ff.n2_im) - tffa_pkg::ext_word(s2i2_ff),
                                 1'b0);
      c3_in       = c2_ff;
      c3_in.z_re  = zr_fit.val;
      c3_in.z_neg = zi_fit.val[tffa_pkg::DATA_WIDTH-1];
      c3_in.ovf   = c2_ff.ovf | zr_fit.ovf | zi_fit.ovf;
   end

   always_ff @(posedge clock) begin
      c3_ff  <= c3_in;
      zi3_ff <= zi_fit.val;
   end

   // stage 4: squares for |Z|
   tffa_pkg::carry_type c4_ff;
   tffa_pkg::prod_type  sqr4_ff, sqi4_ff;

   always_ff @(posedge clock) begin
      sqr4_ff <= c3_ff.z_re * c3_ff.z_re;
      sqi4_ff <= zi3_ff * zi3_ff;
      c4_ff   <= c3_ff;
   end

   // |Z| root, one bit per stage
   tffa_pkg::sqrt_type  sq1_ff  [0:tffa_pkg::ROOT_W];
   tffa_pkg::carry_type csq1_ff [0:tffa_pkg::ROOT_W];

   always_ff @(posedge clock) begin
      sq1_ff[0].rem  <= $unsigned(sqr4_ff) + $unsigned(sqi4_ff);
      sq1_ff[0].root <= '0;
      csq1_ff[0]     <= c4_ff;
      for (int k = 0; k < tffa_pkg::ROOT_W; k++) begin
         sq1_ff[k+1]  <= tffa_pkg::sqrt_step(sq1_ff[k], tffa_pkg::ROOT_W - 1 - k);
         csq1_ff[k+1] <= csq1_ff[k];
      end
   end

   // half-angle radicands (|Z| +- Re Z) / 2 scaled, both roots side by side
   logic signed [tffa_pkg::DATA_WIDTH+1:0] pe, qe;
   tffa_pkg::sqrt_type  sq2_ff  [0:tffa_pkg::ROOT_W];
   tffa_pkg::sqrt_type  sq3_ff  [0:tffa_pkg::ROOT_W];
   tffa_pkg::carry_type csq2_ff [0:tffa_pkg::ROOT_W];

   assign pe = $signed({2'b00, sq1_ff[tffa_pkg::ROOT_W].root})
             + $signed({{2{csq1_ff[tffa_pkg::ROOT_W].z_re[tffa_pkg::DATA_WIDTH-1]}},
                        csq1_ff[tffa_pkg::ROOT_W].z_re});
   assign qe = $signed({2'b00, sq1_ff[tffa_pkg::ROOT_W].root})
             - $signed({{2{csq1_ff[tffa_pkg::ROOT_W].z_re[tffa_pkg::DATA_WIDTH-1]}},
                        csq1_ff[tffa_pkg::ROOT_W].z_re});

   always_ff @(posedge clock) begin
      sq2_ff[0].rem  <= tffa_pkg::RAD_W'(pe[tffa_pkg::DATA_WIDTH:0]) << (tffa_pkg::FRAC_BITS - 1);
      sq2_ff[0].root <= '0;
      sq3_ff[0].rem  <= tffa_pkg::RAD_W'(qe[tffa_pkg::DATA_WIDTH:0]) << (tffa_pkg::FRAC_BITS - 1);
      sq3_ff[0].root <= '0;
      csq2_ff[0]     <= csq1_ff[tffa_pkg::ROOT_W];
      for (int k = 0; k < tffa_pkg::ROOT_W; k++) begin
         sq2_ff[k+1]  <= tffa_pkg::sqrt_step(sq2_ff[k], tffa_pkg::ROOT_W - 1 - k);
         sq3_ff[k+1]  <= tffa_pkg::sqrt_step(sq3_ff[k], tffa_pkg::ROOT_W - 1 - k);
         csq2_ff[k+1] <= csq2_ff[k];
      end
   end

   // stage 7: principal root of Z
   tffa_pkg::carry_type c7_in, c7_ff;

   always_comb begin
      c7_in      = csq2_ff[tffa_pkg::ROOT_W];
      c7_in.y_re = sq2_ff[tffa_pkg::ROOT_W].root;
      c7_in.y_im = csq2_ff[tffa_pkg::ROOT_W].z_neg ? -sq3_ff[tffa_pkg::ROOT_W].root
                                                   : sq3_ff[tffa_pkg::ROOT_W].root;
   end

   always_ff @(posedge clock) begin
      c7_ff <= c7_in;
   end

   // stage 8: products for N^2 / root
   tffa_pkg::carry_type c8_ff;
   tffa_pkg::prod_type  d_rr_ff, d_ii_ff, d_nr_ff, d_ni_ff, d_ir_ff, d_ri_ff;

   always_ff @(posedge clock) begin
      d_rr_ff <= c7_ff.y_re * c7_ff.y_re;
      d_ii_ff <= c7_ff.y_im * c7_ff.y_im;
      d_nr_ff <= c7_ff.n2_re * c7_ff.y_re;
      d_ni_ff <= c7_ff.n2_im * c7_ff.y_im;
      d_ir_ff <= c7_ff.n2_im * c7_ff.y_re;
      d_ri_ff <= c7_ff.n2_re * c7_ff.y_im;
      c8_ff   <= c7_ff;
   end

   // stage 9: numerators and divisor
   tffa_pkg::carry_type           c9_ff;
   tffa_pkg::sum_type             numr_s, numi_s, numr_abs, numi_abs;
   logic [tffa_pkg::RAD_W-1:0]    den9_ff, numr9_ff, numi9_ff;
   logic                          numr_neg9_ff, numi_neg9_ff;

   assign numr_s   = tffa_pkg::ext_prod(d_nr_ff) + tffa_pkg::ext_prod(d_ni_ff);
   assign numi_s   = tffa_pkg::ext_prod(d_ir_ff) - tffa_pkg::ext_prod(d_ri_ff);
   assign numr_abs = numr_s[tffa_pkg::SUM_W-1] ? -numr_s : numr_s;
   assign numi_abs = numi_s[tffa_pkg::SUM_W-1] ? -numi_s : numi_s;

   always_ff @(posedge clock) begin
      den9_ff      <= $unsigned(d_rr_ff) + $unsigned(d_ii_ff);
      numr9_ff     <= numr_abs[tffa_pkg::RAD_W-1:0];
      numi9_ff     <= numi_abs[tffa_pkg::RAD_W-1:0];
      numr_neg9_ff <= numr_s[tffa_pkg::SUM_W-1];
      numi_neg9_ff <= numi_s[tffa_pkg::SUM_W-1];
      c9_ff        <= c8_ff;
   end

   // quotient units, one bit per stage
   logic [tffa_pkg::DIV_W-1:0] numr_sh, numi_sh, den_sh;
   tffa_pkg::div_type   dvr_ff [0:tffa_pkg::QUO_W];
   tffa_pkg::div_type   dvi_ff [0:tffa_pkg::QUO_W];
   tffa_pkg::carry_type cdv_ff [0:tffa_pkg::QUO_W];

   assign numr_sh = tffa_pkg::DIV_W'(numr9_ff) << tffa_pkg::FRAC_BITS;
   assign numi_sh = tffa_pkg::DIV_W'(numi9_ff) << tffa_pkg::FRAC_BITS;
   assign den_sh  = tffa_pkg::DIV_W'(den9_ff) << tffa_pkg::QUO_W;

   always_ff @(posedge clock) begin
      dvr_ff[0].rem <= numr_sh;
      dvr_ff[0].den <= den9_ff;
      dvr_ff[0].quo <= '0;
      dvr_ff[0].big <= numr_sh >= den_sh;
      dvr_ff[0].neg <= numr_neg9_ff;
      dvi_ff[0].rem <= numi_sh;
      dvi_ff[0].den <= den9_ff;
      dvi_ff[0].quo <= '0;
      dvi_ff[0].big <= numi_sh >= den_sh;
      dvi_ff[0].neg <= numi_neg9_ff;
      cdv_ff[0]     <= c9_ff;
      for (int k = 0; k < tffa_pkg::QUO_W; k++) begin
         dvr_ff[k+1] <= tffa_pkg::div_step(dvr_ff[k], tffa_pkg::QUO_W - 1 - k);
         dvi_ff[k+1] <= tffa_pkg::div_step(dvi_ff[k], tffa_pkg::QUO_W - 1 - k);
         cdv_ff[k+1] <= cdv_ff[k];
      end
   end

   // stage 11: admittance by polarization
   tffa_pkg::carry_type c11_in, c11_ff;
   tffa_pkg::fit_type   qr_fit, qi_fit;

   always_comb begin
      qr_fit = tffa_pkg::quo_fit(dvr_ff[tffa_pkg::QUO_W]);
      qi_fit = tffa_pkg::quo_fit(dvi_ff[tffa_pkg::QUO_W]);
      c11_in = cdv_ff[tffa_pkg::QUO_W];
      if (c11_in.mode) begin
         if (c11_in.y_re == '0 && c11_in.y_im == '0) begin
            c11_in.zdiv = 1'b1;
         end else begin
            c11_in.y_re = qr_fit.val;
            c11_in.y_im = qi_fit.val;
            c11_in.ovf  = c11_in.ovf | qr_fit.ovf | qi_fit.ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      c11_ff <= c11_in;
   end

   // stage 12: branch fix, negate when the real part is zero
   tffa_pkg::carry_type c12_in, c12_ff;
   tffa_pkg::fit_type   neg_fit;

   always_comb begin
      neg_fit = tffa_pkg::sat_fit(-tffa_pkg::ext_word(c11_ff.y_im), 1'b0);
      c12_in  = c11_ff;
      if (c11_ff.y_re == '0) begin
         c12_in.y_im = neg_fit.val;
         c12_in.ovf  = c11_ff.ovf | neg_fit.ovf;
      end
   end

   always_ff @(posedge clock) begin
      c12_ff <= c12_in;
   end

   // stage 13: m12 * Y
   tffa_pkg::carry_type c13_ff;
   tffa_pkg::prod_type  e1_ff, e2_ff, e3_ff, e4_ff;

   always_ff @(posedge clock) begin
      e1_ff  <= c12_ff.m12_re * c12_ff.y_re;
      e2_ff  <= c12_ff.m12_im * c12_ff.y_im;
      e3_ff  <= c12_ff.m12_re * c12_ff.y_im;
      e4_ff  <= c12_ff.m12_im * c12_ff.y_re;
      c13_ff <= c12_ff;
   end

   // stage 14: B = m11 + m12*Y
   tffa_pkg::fit_type  br_fit, bi_fit;
   tffa_pkg::word_type br14_ff, bi14_ff;
   logic               ovf14_ff, zdiv14_ff;

   always_comb begin
      br_fit = tffa_pkg::sat_fit((tffa_pkg::ext_word(c13_ff.m11_re) <<< tffa_pkg::FRAC_BITS)
                                 + tffa_pkg::ext_prod(e1_ff) - tffa_pkg::ext_prod(e2_ff), 1'b1);
      bi_fit = tffa_pkg::sat_fit((tffa_pkg::ext_word(c13_ff.m11_im) <<< tffa_pkg::FRAC_BITS)
                                 + tffa_pkg::ext_prod(e3_ff) + tffa_pkg::ext_prod(e4_ff), 1'b1);
   end

   always_ff @(posedge clock) begin
      br14_ff   <= br_fit.val;
      bi14_ff   <= bi_fit.val;
      ovf14_ff  <= c13_ff.ovf | br_fit.ovf | bi_fit.ovf;
      zdiv14_ff <= c13_ff.zdiv;
   end

   // stage 15: squares for |B|
   tffa_pkg::prod_type sbr15_ff, sbi15_ff;
   logic               ovf15_ff, zdiv15_ff;

   always_ff @(posedge clock) begin
      sbr15_ff  <= br14_ff * br14_ff;
      sbi15_ff  <= bi14_ff * bi14_ff;
      ovf15_ff  <= ovf14_ff;
      zdiv15_ff <= zdiv14_ff;
   end

   // |B| root
   tffa_pkg::sqrt_type          sq4_ff [0:tffa_pkg::ROOT_W];
   logic [tffa_pkg::ROOT_W:0]   ovf4_ff, zdiv4_ff;

   always_ff @(posedge clock) begin
      sq4_ff[0].rem  <= $unsigned(sbr15_ff) + $unsigned(sbi15_ff);
      sq4_ff[0].root <= '0;
      ovf4_ff        <= {ovf4_ff[tffa_pkg::ROOT_W-1:0], ovf15_ff};
      zdiv4_ff       <= {zdiv4_ff[tffa_pkg::ROOT_W-1:0], zdiv15_ff};
      for (int k = 0; k < tffa_pkg::ROOT_W; k++) begin
         sq4_ff[k+1] <= tffa_pkg::sqrt_step(sq4_ff[k], tffa_pkg::ROOT_W - 1 - k);
      end
   end

   // output register with final saturation
   logic mag_sat;

   assign mag_sat = sq4_ff[tffa_pkg::ROOT_W].root[tffa_pkg::ROOT_W-1];

   always_ff @(posedge clock) begin
      rsp_field_magnitude   <= mag_sat ? '1
                                       : sq4_ff[tffa_pkg::ROOT_W].root[tffa_pkg::DATA_WIDTH-2:0];
      rsp_overflow_flag     <= ovf4_ff[tffa_pkg::ROOT_W] | mag_sat;
      rsp_zero_divisor_flag <= zdiv4_ff[tffa_pkg::ROOT_W];
   end

   `TFFA_ASSERT(a_fixed_latency, (start && !busy) |-> ##(tffa_pkg::PIPE_DEPTH) rsp_valid)
   `TFFA_ASSERT(a_modulus_covers_real,
      valid_ff[tffa_pkg::ROOT_W+4] |->
      (!pe[tffa_pkg::DATA_WIDTH+1] && !qe[tffa_pkg::DATA_WIDTH+1]))
   `TFFA_ASSERT(a_quotient_remainder,
      (valid_ff[2*tffa_pkg::ROOT_W+9+tffa_pkg::QUO_W] && cdv_ff[tffa_pkg::QUO_W].mode
       && !dvr_ff[tffa_pkg::QUO_W].big) |->
      (dvr_ff[tffa_pkg::QUO_W].rem < tffa_pkg::DIV_W'(dvr_ff[tffa_pkg::QUO_W].den)))
   `TFFA_ASSERT_NEXT(a_mode_write, csr_valid && csr_ready, mode_ff == $past(csr_polarization_mode))

endmodule
`default_nettype wire
